FILE: sv/slot_pool_with_fifo_waiters_assert.svh
// Assertion macros shared by the slot pool RTL.
`ifndef SLOT_POOL_WITH_FIFO_WAITERS_ASSERT_SVH
`define SLOT_POOL_WITH_FIFO_WAITERS_ASSERT_SVH

// Condition must hold at every clock edge out of reset.
`define SPW_ASSERT_ALWAYS(name, clk, rst_n, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define SPW_ASSERT_IMPLIES(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define SPW_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/spw_pkg.sv
// Package for the slot pool: field widths, codes, defaults and payload types.
package spw_pkg;

    // Default sizing
    localparam int SLOTS_DEF      = 16;
    localparam int WAIT_DEPTH_DEF = 16;

    // Payload field widths
    localparam int OP_W     = 1;
    localparam int TAG_W    = 8;
    localparam int SLOT_IDX_W = 4;
    localparam int STATUS_W = 3;

    // Operation codes
    localparam logic [OP_W-1:0] OP_REQUEST = 1'b0;
    localparam logic [OP_W-1:0] OP_RELEASE = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_GRANTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_QUEUED   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_HANDED   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FREED    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_REJECTED = 3'd4;

    // Incoming request
    typedef struct packed {
        logic [OP_W-1:0]       operation;
        logic [TAG_W-1:0]      requester_tag;
        logic [SLOT_IDX_W-1:0] slot_index;
    } cmd_t;

    // Outgoing result
    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [TAG_W-1:0]      grant_tag;
        logic [SLOT_IDX_W-1:0] grant_slot;
    } rsp_t;

endpackage

FILE: sv/slot_pool_with_fifo_waiters.sv
// Slot pool allocator with a FIFO of waiting requesters (top level).
//
// A request is handled in an accept cycle and an execute cycle: in the accept
// cycle the waiter memory is read at the head pointer, and in the execute cycle
// (busy high) the block decides, updates the busy map and pointers and writes
// a queued tag into the waiter memory. The result appears for exactly one
// cycle with done high on the cycle after that, and a new request can be
// accepted in that same cycle; no new request is taken while one executes,
// as the waiter memory read is registered. The receiver cannot stall: a result
// must be taken in the cycle that done is high. A request takes the lowest
// free slot or queues its tag (rejected when the queue is full); a release
// hands the slot to the oldest waiter or frees it (out of range: no change).
module slot_pool_with_fifo_waiters #(
    parameter int SLOTS      = spw_pkg::SLOTS_DEF,
    parameter int WAIT_DEPTH = spw_pkg::WAIT_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  spw_pkg::cmd_t cmd,
    output logic          done,
    output spw_pkg::rsp_t result
);

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int PTR_W  = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
    localparam int CNT_W  = $clog2(WAIT_DEPTH + 1);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    // Control state
    logic                state_reg, state_next;
    logic [SLOTS-1:0]    busy_map_reg, busy_map_next;
    logic [PTR_W-1:0]    head_reg, head_next;
    logic [PTR_W-1:0]    tail_reg, tail_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                done_reg, done_next;

    // Payload registers
    spw_pkg::cmd_t       cmd_reg;
    spw_pkg::rsp_t       rsp_reg, rsp_next;

    // Waiter memory
    logic [spw_pkg::TAG_W-1:0] waiter_mem [WAIT_DEPTH];
    logic [spw_pkg::TAG_W-1:0] rd_data_reg;
    logic                      wr_en;

    // Find-first-free results
    logic                          any_free;
    logic [SLOT_W-1:0]             free_idx;
    logic [spw_pkg::SLOT_IDX_W-1:0] free_slot;

    logic accept;
    logic in_range;

    assign accept = start && (state_reg == S_IDLE);
    assign busy   = (state_reg == S_EXEC);
    assign done   = done_reg;
    assign result = rsp_reg;

    // Lowest free slot
    always_comb
    begin
        any_free  = 1'b0;
        free_idx  = '0;
        free_slot = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!busy_map_reg[i])
            begin
                any_free  = 1'b1;
                free_idx  = SLOT_W'(i);
                free_slot = spw_pkg::SLOT_IDX_W'(i);
            end
        end
    end

    assign in_range = (32'(cmd_reg.slot_index) < 32'(SLOTS));

    // Decide and update in the execute cycle
    always_comb
    begin
        state_next    = state_reg;
        busy_map_next = busy_map_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        count_next    = count_reg;
        done_next     = 1'b0;
        rsp_next      = rsp_reg;
        wr_en         = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next          = S_IDLE;
                done_next           = 1'b1;
                rsp_next.grant_tag  = '0;
                rsp_next.grant_slot = '0;
                if (cmd_reg.operation == spw_pkg::OP_REQUEST)
                begin
                    if (any_free)
                    begin
                        busy_map_next       = busy_map_reg | (SLOTS'(1) << free_idx);
                        rsp_next.status     = spw_pkg::ST_GRANTED;
                        rsp_next.grant_tag  = cmd_reg.requester_tag;
                        rsp_next.grant_slot = free_slot;
                    end
                    else if (count_reg == CNT_W'(WAIT_DEPTH))
                    begin
                        rsp_next.status = spw_pkg::ST_REJECTED;
                    end
                    else
                    begin
                        wr_en           = 1'b1;
                        tail_next       = (tail_reg == PTR_W'(WAIT_DEPTH - 1)) ?
                                          '0 : tail_reg + PTR_W'(1);
                        count_next      = count_reg + CNT_W'(1);
                        rsp_next.status = spw_pkg::ST_QUEUED;
                    end
                end
                else if (!in_range)
                begin
                    rsp_next.status = spw_pkg::ST_FREED;
                end
                else if (count_reg != '0)
                begin
                    // hand the slot straight to the oldest waiter
                    head_next           = (head_reg == PTR_W'(WAIT_DEPTH - 1)) ?
                                          '0 : head_reg + PTR_W'(1);
                    count_next          = count_reg - CNT_W'(1);
                    busy_map_next       = busy_map_reg | (SLOTS'(1) << cmd_reg.slot_index);
                    rsp_next.status     = spw_pkg::ST_HANDED;
                    rsp_next.grant_tag  = rd_data_reg;
                    rsp_next.grant_slot = cmd_reg.slot_index;
                end
                else
                begin
                    busy_map_next   = busy_map_reg & ~(SLOTS'(1) << cmd_reg.slot_index);
                    rsp_next.status = spw_pkg::ST_FREED;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            busy_map_reg <= '0;
            head_reg     <= '0;
            tail_reg     <= '0;
            count_reg    <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            busy_map_reg <= busy_map_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            count_reg    <= count_next;
            done_reg     <= done_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd;
        end
        rsp_reg <= rsp_next;
    end

    // Waiter memory: one write port, one registered read at the head
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            waiter_mem[tail_reg] <= cmd_reg.requester_tag;
        end
        rd_data_reg <= waiter_mem[head_reg];
    end

`include "slot_pool_with_fifo_waiters_assert.svh"

    `SPW_ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_reg <= CNT_W'(WAIT_DEPTH), "waiter count beyond queue depth")
    `SPW_ASSERT_IMPLIES(a_wait_all_busy, clk, rst_n, count_reg != '0, &busy_map_reg, "waiters queued while a slot is free")
    `SPW_ASSERT_NEXT(a_exec_done, clk, rst_n, state_reg == S_EXEC, done_reg && state_reg == S_IDLE, "execute cycle gave no result")
    `SPW_ASSERT_NEXT(a_accept_exec, clk, rst_n, accept, state_reg == S_EXEC && !done_reg, "accepted request not executed")

endmodule

FILE: tb/tb_slot_pool_with_fifo_waiters.sv
// Self-checking testbench for the slot pool allocator with FIFO waiters.
`timescale 1ns / 1ps

module tb_slot_pool_with_fifo_waiters;
    import spw_pkg::*;

    localparam int RANDOM_ITEMS = 1350;
    localparam int DRAIN_CYCLES = 8;

    logic  clk   = 1'b0;
    logic  rst_n = 1'b0;
    logic  start = 1'b0;
    cmd_t  cmd   = '0;
    logic  busy;
    logic  done;
    rsp_t  result;

    // Requests waiting to be driven, and results predicted for accepted ones
    cmd_t  pending_cmds[$];
    rsp_t  expected_results[$];

    // Shadow copy of the pool state
    logic [SLOTS_DEF-1:0] busy_slots;
    logic [TAG_W-1:0]     waiting_tags[WAIT_DEPTH_DEF];
    int                   wait_head;
    int                   wait_tail;
    int                   wait_count;

    int    error_count    = 0;
    int    accepted_count = 0;
    int    total_items    = 0;
    int    sender_idle_pct;
    rsp_t  oldest_expected;

    slot_pool_with_fifo_waiters DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .done   (done),
        .result (result)
    );

    always #5 clk = ~clk;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    // Apply one request to the shadow pool and work out its result
    task automatic pool_update(input cmd_t c, output rsp_t r);
        int  i;
        bit  found;
        r     = '0;
        found = 1'b0;
        if (c.operation == OP_REQUEST) begin
            // lowest free slot wins
            for (i = 0; i < SLOTS_DEF; i++) begin
                if (!found && !busy_slots[i]) begin
                    busy_slots[i] = 1'b1;
                    r.status      = ST_GRANTED;
                    r.grant_tag   = c.requester_tag;
                    r.grant_slot  = SLOT_IDX_W'(i);
                    found         = 1'b1;
                end
            end
            if (!found) begin
                if (wait_count >= WAIT_DEPTH_DEF) begin
                    r.status = ST_REJECTED;
                end
                else begin
                    waiting_tags[wait_tail] = c.requester_tag;
                    wait_tail  = (wait_tail + 1) % WAIT_DEPTH_DEF;
                    wait_count++;
                    r.status   = ST_QUEUED;
                end
            end
        end
        else if (int'(c.slot_index) >= SLOTS_DEF) begin
            // out-of-range release is ignored
            r.status = ST_FREED;
        end
        else if (wait_count > 0) begin
            // hand the slot to the oldest waiter; slot stays busy
            r.status     = ST_HANDED;
            r.grant_tag  = waiting_tags[wait_head];
            r.grant_slot = c.slot_index;
            wait_head    = (wait_head + 1) % WAIT_DEPTH_DEF;
            wait_count--;
            busy_slots[c.slot_index] = 1'b1;
        end
        else begin
            busy_slots[c.slot_index] = 1'b0;
            r.status = ST_FREED;
        end
    endtask

    task automatic add_cmd(input logic [OP_W-1:0] op, input logic [TAG_W-1:0] tag,
                           input logic [SLOT_IDX_W-1:0] slot);
        cmd_t c;
        c.operation     = op;
        c.requester_tag = tag;
        c.slot_index    = slot;
        pending_cmds.push_back(c);
    endtask

    // Sender idle rate: 24% for the first third, 84% for the second, none after
    always_comb begin
        if (accepted_count < total_items / 3)
            sender_idle_pct = 24;
        else if (accepted_count < (2 * total_items) / 3)
            sender_idle_pct = 84;
        else
            sender_idle_pct = 0;
    end

    // Driver: predicts at acceptance, then presents the next request or idles
    always @(posedge clk) begin
        rsp_t predicted;
        if (!rst_n) begin
            start <= 1'b0;
        end
        else begin
            if (start && !busy) begin
                pool_update(cmd, predicted);
                expected_results.push_back(predicted);
                void'(pending_cmds.pop_front());
                accepted_count++;
            end
            // hold the current request while the block is busy
            if (!start || !busy) begin
                if (pending_cmds.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                    start <= 1'b1;
                    cmd   <= pending_cmds[0];
                end
                else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: every done strobe is checked against the oldest prediction
    always @(posedge clk) begin
        if (rst_n && done) begin
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result status=%0d tag=%0d slot=%0d",
                                          result.status, result.grant_tag, result.grant_slot));
            end
            else begin
                oldest_expected = expected_results.pop_front();
                if (result.status !== oldest_expected.status)
                    report_mismatch($sformatf("status got %0d want %0d",
                                              result.status, oldest_expected.status));
                if (result.grant_tag !== oldest_expected.grant_tag)
                    report_mismatch($sformatf("grant_tag got %0d want %0d",
                                              result.grant_tag, oldest_expected.grant_tag));
                if (result.grant_slot !== oldest_expected.grant_slot)
                    report_mismatch($sformatf("grant_slot got %0d want %0d",
                                              result.grant_slot, oldest_expected.grant_slot));
            end
        end
    end

    // Stimulus, reset and end of run
    initial begin
        int i;
        int seg_len;
        int req_pct;
        int random_left;

        busy_slots = '0;
        wait_head  = 0;
        wait_tail  = 0;
        wait_count = 0;

        // releases of free slots with nobody waiting
        add_cmd(OP_RELEASE, 8'h00, 4'd0);
        add_cmd(OP_RELEASE, 8'hFF, 4'd15);
        // grants, then reuse of a freed low slot
        add_cmd(OP_REQUEST, 8'h00, 4'd0);
        add_cmd(OP_REQUEST, 8'hFF, 4'd15);
        add_cmd(OP_RELEASE, 8'h00, 4'd0);
        add_cmd(OP_REQUEST, 8'hA5, 4'd0);
        // fill the remaining slots
        for (i = 0; i < 14; i++)
            add_cmd(OP_REQUEST, TAG_W'(8'h5A + i), SLOT_IDX_W'(i));
        // queue two waiters, hand slots to them in order, then free one
        add_cmd(OP_REQUEST, 8'h81, 4'd0);
        add_cmd(OP_REQUEST, 8'h7E, 4'd0);
        add_cmd(OP_RELEASE, 8'h00, 4'd15);
        add_cmd(OP_RELEASE, 8'h00, 4'd3);
        add_cmd(OP_RELEASE, 8'h00, 4'd3);

        // request burst that overflows the waiter queue, then a drain
        for (i = 0; i < 24; i++)
            add_cmd(OP_REQUEST, TAG_W'($urandom_range(255)), '0);
        for (i = 0; i < 24; i++)
            add_cmd(OP_RELEASE, TAG_W'($urandom_range(255)), SLOT_IDX_W'($urandom_range(15)));

        // random bursts leaning toward requests, a mix, or releases
        random_left = RANDOM_ITEMS - 48;
        while (random_left > 0) begin
            seg_len = $urandom_range(8, 48);
            case ($urandom_range(2))
                0:       req_pct = 85;
                1:       req_pct = 50;
                default: req_pct = 15;
            endcase
            for (i = 0; i < seg_len && random_left > 0; i++) begin
                add_cmd(($urandom_range(99) < req_pct) ? OP_REQUEST : OP_RELEASE,
                        TAG_W'($urandom_range(255)), SLOT_IDX_W'($urandom_range(15)));
                random_left--;
            end
        end
        total_items = pending_cmds.size();

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_cmds.size() != 0 || start || expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Watchdog, far beyond the slowest correct run
    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
